// File: rtl/mfes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfes_pkg: shared types and constants of the edge-shrinking median filter
// Pixel and register widths, register indexes, input action codes and the
// control word that travels down the rank chain.
// ----------------------------------------------------------------------------
package mfes_pkg;

  localparam int PIX_W         = 8;
  localparam int CFG_W         = 11;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int RADIUS_DEF    = 2;
  localparam int MAX_HEIGHT    = 1024;
  // Ranks and targets stay below 49 for every supported radius.
  localparam int RANK_W        = 6;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } action_t;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic [RANK_W-1:0] target;
  } rank_ctl_t;

endpackage
`default_nettype wire

// File: rtl/mfes_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfes_in_if / mfes_out_if: valid/ready channels of the median filter
// One word moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface mfes_in_if;
  import mfes_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, action, pixel, input ready);
  modport sink   (input valid, action, pixel, output ready);
endinterface

interface mfes_out_if;
  import mfes_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] median_value;
  logic             last_of_frame;
  modport source (output valid, median_value, last_of_frame, input ready);
  modport sink   (input valid, median_value, last_of_frame, output ready);
endinterface
`default_nettype wire

// File: rtl/mfes_rank_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfes_rank_cell: one cell of the rank chain
// Compares its own window element against every element and adds one to the
// rank of each element it precedes in the ascending order.
// ----------------------------------------------------------------------------
module mfes_rank_cell #(
  parameter int N   = 25,
  parameter int IDX = 0
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic [N-1:0][mfes_pkg::PIX_W-1:0]      vals_i,
  input  logic [N-1:0][mfes_pkg::RANK_W-1:0]     rank_i,
  input  logic [N-1:0]                           mask_i,
  input  mfes_pkg::rank_ctl_t                    ctl_i,
  output logic [N-1:0][mfes_pkg::PIX_W-1:0]      vals_o,
  output logic [N-1:0][mfes_pkg::RANK_W-1:0]     rank_o,
  output logic [N-1:0]                           mask_o,
  output mfes_pkg::rank_ctl_t                    ctl_o
);
  import mfes_pkg::*;

  logic [N-1:0][PIX_W-1:0]  vals_r;
  logic [N-1:0][RANK_W-1:0] rank_r, rank_nxt;
  logic [N-1:0]             mask_r;
  logic                     vld_r;
  logic                     last_r;
  logic [RANK_W-1:0]        target_r;

  // Equal values are ordered by position so every rank is unique.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank_nxt[i] = rank_i[i] + RANK_W'(mask_i[IDX] &&
                    ((vals_i[IDX] < vals_i[i]) ||
                     ((vals_i[IDX] == vals_i[i]) && (i > IDX))));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vals_r   <= vals_i;
      rank_r   <= rank_nxt;
      mask_r   <= mask_i;
      last_r   <= ctl_i.last;
      target_r <= ctl_i.target;
    end
  end

  assign vals_o = vals_r;
  assign rank_o = rank_r;
  assign mask_o = mask_r;
  assign ctl_o  = '{vld: vld_r, last: last_r, target: target_r};

endmodule
`default_nettype wire

// File: rtl/median_filter_5x5_edge_shrink.sv
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_5x5_edge_shrink: streaming median filter with shrinking edges
// Raster pixels in, one median per image position out, neighbours outside the
// image left out of the neighbourhood.
// ----------------------------------------------------------------------------
// The filter takes one word per clock and gives one result per clock once the
// pipeline is full and while the sink takes results. Pixel words arrive in
// raster order; once the image is complete, drain words flush the last
// WINDOW_RADIUS lines plus WINDOW_RADIUS pixels of results (two by default),
// and the result for the final position carries last_of_frame. A result
// leaves the block after the word that completes its neighbourhood has passed
// the line store read register (the window shift feeds the first cell
// directly), one register per cell of the rank chain ((2*WINDOW_RADIUS+1)^2
// cells, 25 by default) and the output register. The whole pipeline moves
// together: when the output word is held by the sink, in_word.ready drops in
// the same cycle. The line store is one bank per stored line, all read at the
// current column while only the current line's bank is written; no clearing
// pass follows reset. Register writes restart the frame and must only happen while the filter is idle.
// ----------------------------------------------------------------------------
module median_filter_5x5_edge_shrink #(
  parameter int MAX_WIDTH     = mfes_pkg::MAX_WIDTH_DEF,
  parameter int WINDOW_RADIUS = mfes_pkg::RADIUS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mfes_in_if.sink                     in_word,
  mfes_out_if.source                  out_word,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [mfes_pkg::CFG_W-1:0]  cfg_data
);
  import mfes_pkg::*;

  localparam int D   = 2 * WINDOW_RADIUS + 1;
  localparam int N   = D * D;
  localparam int SL  = 2 * WINDOW_RADIUS;
  localparam int LW  = $clog2(SL);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = CW + 1;
  localparam int TW  = WW + CFG_W;
  localparam int CNW = $clog2(D + 1);

  // Configuration registers and the effective image size.
  logic [CFG_W-1:0] cfg_width_r, cfg_height_r;
  logic [WW-1:0]    w_eff_c;
  logic [CFG_W-1:0] h_eff_c;
  logic [TW-1:0]    total_c, lag_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RESET;
      cfg_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero acts as one, and sizes above the maximum saturate.
  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff_c = WW'(1);
    end else if (int'(cfg_width_r) > MAX_WIDTH) begin
      w_eff_c = WW'(MAX_WIDTH);
    end else begin
      w_eff_c = WW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_eff_c = CFG_W'(1);
    end else if (int'(cfg_height_r) > MAX_HEIGHT) begin
      h_eff_c = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff_c = cfg_height_r;
    end
    total_c = TW'(w_eff_c) * TW'(h_eff_c);
    lag_c   = TW'(w_eff_c) * TW'(WINDOW_RADIUS) + TW'(WINDOW_RADIUS);
  end

  // Handshake and per-word decisions.
  logic             adv_c, acc_c, drain_c, fin_c, eff_c, emit_c, last_c;
  logic [PIX_W-1:0] p_c;
  logic             out_valid_r;

  // Position counters: words taken, input column and line, output position.
  logic [TW-1:0]    n_r, n_nxt, on_r, on_nxt;
  logic [CW-1:0]    col_r, col_nxt, ocol_r, ocol_nxt;
  logic [LW-1:0]    line_r, line_nxt;
  logic [CFG_W-1:0] orow_r, orow_nxt;

  assign adv_c   = !out_valid_r || out_word.ready;
  assign acc_c   = in_word.valid && adv_c;
  assign drain_c = (in_word.action == ACT_DRAIN);
  assign fin_c   = (n_r >= total_c);
  // A drain word before the image is complete changes nothing.
  assign eff_c   = acc_c && !(drain_c && !fin_c);
  assign p_c     = (!drain_c && !fin_c) ? in_word.pixel : '0;
  assign emit_c  = (n_r >= lag_c);
  assign last_c  = ((on_r + TW'(1)) >= total_c);

  always_comb begin
    n_nxt    = n_r;
    col_nxt  = col_r;
    line_nxt = line_r;
    on_nxt   = on_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (cfg_we || (eff_c && emit_c && last_c)) begin
      n_nxt    = '0;
      col_nxt  = '0;
      line_nxt = '0;
      on_nxt   = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end else if (eff_c) begin
      n_nxt = n_r + TW'(1);
      if ((WW'(col_r) + WW'(1)) >= w_eff_c) begin
        col_nxt  = '0;
        line_nxt = (line_r == LW'(SL - 1)) ? '0 : line_r + LW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
      if (emit_c) begin
        on_nxt = on_r + TW'(1);
        if ((WW'(ocol_r) + WW'(1)) >= w_eff_c) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + CFG_W'(1);
        end else begin
          ocol_nxt = ocol_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= '0;
      col_r  <= '0;
      line_r <= '0;
      on_r   <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      n_r    <= n_nxt;
      col_r  <= col_nxt;
      line_r <= line_nxt;
      on_r   <= on_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end

  // Which window columns and rows lie inside the image for the output
  // position, and the rank of the median among the elements kept.
  logic [D-1:0]      colok_c, rowok_c;
  logic [CNW-1:0]    ccnt_c, rcnt_c;
  logic [RANK_W-1:0] tgt_c;

  always_comb begin
    logic [WW:0]    ct;
    logic [CFG_W:0] rt;
    ct     = (WW+1)'(ocol_r) + (WW+1)'(WINDOW_RADIUS);
    rt     = (CFG_W+1)'(orow_r) + (CFG_W+1)'(WINDOW_RADIUS);
    ccnt_c = '0;
    rcnt_c = '0;
    for (int k = 0; k < D; k++) begin
      colok_c[k] = (ct >= (WW+1)'(k)) &&
                   ((ct - (WW+1)'(k)) < (WW+1)'(w_eff_c));
      rowok_c[k] = (rt >= (CFG_W+1)'(k)) &&
                   ((rt - (CFG_W+1)'(k)) < (CFG_W+1)'(h_eff_c));
      ccnt_c     = ccnt_c + CNW'(colok_c[k]);
      rcnt_c     = rcnt_c + CNW'(rowok_c[k]);
    end
    tgt_c = (RANK_W'(ccnt_c) * RANK_W'(rcnt_c)) >> 1;
  end

  // Line store: one bank per stored line, all read at the current column
  // while the bank of the current line takes the new pixel.
  logic [PIX_W-1:0] line_mem [SL][MAX_WIDTH];
  logic [PIX_W-1:0] rd_r [SL];

  always_ff @(posedge clk) begin
    if (eff_c) begin
      for (int b = 0; b < SL; b++) begin
        if (line_r == LW'(b)) begin
          line_mem[b][col_r] <= p_c;
        end
        rd_r[b] <= line_mem[b][col_r];
      end
    end
  end

  // Second stage: control that travels with the line store read.
  logic              s1_v_r, s1_emit_r, s1_last_r;
  logic [D-1:0]      s1_colok_r, s1_rowok_r;
  logic [RANK_W-1:0] s1_tgt_r;
  logic [LW-1:0]     s1_line_r;
  logic [PIX_W-1:0]  s1_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv_c) begin
      s1_v_r <= eff_c;
    end
  end

  always_ff @(posedge clk) begin
    if (eff_c) begin
      s1_emit_r  <= emit_c;
      s1_last_r  <= last_c;
      s1_colok_r <= colok_c;
      s1_rowok_r <= rowok_c;
      s1_tgt_r   <= tgt_c;
      s1_line_r  <= line_r;
      s1_p_r     <= p_c;
    end
  end

  // The window holds the last D column vectors; column zero is the newest,
  // and row zero of each column is the newest line.
  logic [D-1:0][D-1:0][PIX_W-1:0] win_r, win_nxt;

  always_comb begin
    logic [LW-1:0] li;
    li            = '0;
    win_nxt[0][0] = s1_p_r;
    for (int j = 1; j < D; j++) begin
      li = (int'(s1_line_r) >= j) ? LW'(int'(s1_line_r) - j)
                                   : LW'(int'(s1_line_r) + SL - j);
      win_nxt[0][j] = rd_r[li];
    end
    for (int k = 1; k < D; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (adv_c && s1_v_r) begin
      win_r <= win_nxt;
    end
  end

  // Rank chain: the shifted window enters cell zero; each cell ranks one
  // element against the rest and hands everything on to the next cell.
  logic [N-1:0][PIX_W-1:0]  c_vals [N+1];
  logic [N-1:0][RANK_W-1:0] c_rank [N+1];
  logic [N-1:0]             c_mask [N+1];
  rank_ctl_t                c_ctl  [N+1];

  always_comb begin
    for (int k = 0; k < D; k++) begin
      for (int j = 0; j < D; j++) begin
        c_vals[0][k*D+j] = win_nxt[k][j];
        c_mask[0][k*D+j] = s1_colok_r[k] && s1_rowok_r[j];
      end
    end
    c_rank[0]        = '0;
    c_ctl[0].vld     = s1_v_r && s1_emit_r;
    c_ctl[0].last    = s1_last_r;
    c_ctl[0].target  = s1_tgt_r;
  end

  for (genvar s = 0; s < N; s++) begin : g_cell
    mfes_rank_cell #(
      .N   (N),
      .IDX (s)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv_c),
      .vals_i (c_vals[s]),
      .rank_i (c_rank[s]),
      .mask_i (c_mask[s]),
      .ctl_i  (c_ctl[s]),
      .vals_o (c_vals[s+1]),
      .rank_o (c_rank[s+1]),
      .mask_o (c_mask[s+1]),
      .ctl_o  (c_ctl[s+1])
    );
  end

  // Exactly one kept element carries the target rank.
  logic [PIX_W-1:0] sel_c;

  always_comb begin
    sel_c = '0;
    for (int i = 0; i < N; i++) begin
      if (c_mask[N][i] && (c_rank[N][i] == c_ctl[N].target)) begin
        sel_c = c_vals[N][i];
      end
    end
  end

  // Output register.
  logic [PIX_W-1:0] out_med_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_c) begin
      out_valid_r <= c_ctl[N].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      out_med_r  <= sel_c;
      out_last_r <= c_ctl[N].last;
    end
  end

  assign in_word.ready          = adv_c;
  assign out_word.valid         = out_valid_r;
  assign out_word.median_value  = out_med_r;
  assign out_word.last_of_frame = out_last_r;

`ifndef SYNTHESIS
  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (n_r == '0) && (on_r == '0) && (col_r == '0))
    else $error("register write did not restart the frame");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (eff_c && emit_c && last_c && !cfg_we) |=> (n_r == '0) && (ocol_r == '0))
    else $error("final result did not restart the frame");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && !out_word.ready) |-> !in_word.ready)
    else $error("input taken while output word is held");

  a_columns_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (WW'(col_r) < w_eff_c) && (WW'(ocol_r) < w_eff_c))
    else $error("column counter beyond image width");
`endif

endmodule
`default_nettype wire
